### rtl/ffra_pkg.sv
// Package for the first-fit region allocator.
// Holds the descriptor record type and the kind, status and register codes.
// No dependencies.
package ffra_pkg;

  localparam logic [1:0] KIND_UNUSED = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_ALLOC  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NO_FIT  = 2'd2;
  localparam logic [1:0] ST_NO_DESC = 2'd3;

  localparam logic [1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [1:0] REG_POOL_BYTES = 2'd1;

  localparam logic FUNC_FREE = 1'b1;

  localparam logic [31:0] POOL_BASE_RESET  = 32'h0C00_0000;
  localparam logic [31:0] POOL_BYTES_RESET = 32'h0100_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
  } rec_t;

endpackage

### rtl/ffra_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/first_fit_region_allocator.sv
// Top level of the first-fit region allocator with lazy coalescing.
// Depends on ffra_pkg and ffra_ram (descriptor memory).
//
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | func_i, alloc_size_i, free_address_i
// out     | output    | out_valid_o/out_ready_i| granted_address_o, status_o
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One transaction at a time. An allocate walks the free list, merging each free region it
// visits with its successor when the two are adjacent, then scans for a spare descriptor
// and inserts the new allocated region into the allocated list in address order. A free
// searches the allocated list for the address and inserts the region into the free list
// in address order.
// After reset and after every register write a clearing pass rebuilds the memory; no input
// transaction is accepted meanwhile.
// A result waiting on out_ready_i holds the block in its final state; a new input
// transaction is accepted while the previous result still waits.
module first_fit_region_allocator
  import ffra_pkg::*;
#(
  parameter int DESCRIPTORS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [31:0] alloc_size_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int IW    = $clog2(DESCRIPTORS);
  localparam int LW    = IW + 1;
  localparam int REC_W = $bits(rec_t);
  localparam int W     = LW + REC_W;
  localparam logic [LW-1:0] NONE     = {1'b1, {IW{1'b0}}};
  localparam logic [LW-1:0] CNT_END  = LW'(DESCRIPTORS);
  localparam logic [IW-1:0] IDX_LAST = IW'(DESCRIPTORS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_CUR = 4'd3;
  localparam logic [3:0] S_A_NXT = 4'd4;
  localparam logic [3:0] S_A_MRG = 4'd5;
  localparam logic [3:0] S_A_FIT = 4'd6;
  localparam logic [3:0] S_A_REL = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_F_RD  = 4'd9;
  localparam logic [3:0] S_F_CHK = 4'd10;
  localparam logic [3:0] S_I_RD  = 4'd11;
  localparam logic [3:0] S_I_CHK = 4'd12;
  localparam logic [3:0] S_I_WR1 = 4'd13;
  localparam logic [3:0] S_I_WR2 = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]    state_q, state_d;
  logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, cur_link_q, cur_link_d;
  rec_t          cur_rec_q, cur_rec_d, prev_rec_q, prev_rec_d, d_rec_q, d_rec_d;
  logic          exact_q, exact_d, ins_alloc_q, ins_alloc_d, pend_q, pend_d;
  logic [31:0]   size_q, size_d, addr_q, addr_d;
  logic [IW-1:0] d_q, d_d, chk_q, chk_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] free_head_q, free_head_d, alloc_head_q, alloc_head_d;
  logic [31:0]   pool_base_q, pool_base_d, pool_bytes_q, pool_bytes_d;
  logic [31:0]   res_addr_q, res_addr_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [31:0]   out_addr_q, out_addr_d;
  logic [1:0]    out_status_q, out_status_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;
  logic [LW-1:0] rd_link;
  rec_t          rd_rec, tmp_rec;
  logic [32:0]   end_sum, len_sum;
  logic          cfg_hit;

  assign rd_link = ram_rdata[W-1 -: LW];
  assign rd_rec  = rec_t'(ram_rdata[REC_W-1:0]);
  assign end_sum = {1'b0, cur_rec_q.start} + {1'b0, cur_rec_q.length};
  assign len_sum = {1'b0, cur_rec_q.length} + {1'b0, rd_rec.length};
  assign cfg_hit = cfg_valid_i && (cfg_index_i == REG_POOL_BASE ||
                                   cfg_index_i == REG_POOL_BYTES);

  assign in_ready_o        = (state_q == S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    cur_link_d   = cur_link_q;
    cur_rec_d    = cur_rec_q;
    prev_rec_d   = prev_rec_q;
    d_rec_d      = d_rec_q;
    exact_d      = exact_q;
    ins_alloc_d  = ins_alloc_q;
    pend_d       = pend_q;
    size_d       = size_q;
    addr_d       = addr_q;
    d_d          = d_q;
    chk_d        = chk_q;
    cnt_d        = cnt_q;
    free_head_d  = free_head_q;
    alloc_head_d = alloc_head_q;
    pool_base_d  = pool_base_q;
    pool_bytes_d = pool_bytes_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = cur_q[IW-1:0];
    ram_raddr    = cur_q[IW-1:0];
    ram_wdata    = {cur_link_q, cur_rec_q};
    tmp_rec      = cur_rec_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          size_d     = alloc_size_i;
          addr_d     = free_address_i;
          prev_d     = NONE;
          res_addr_d = '0;
          if (func_i == FUNC_FREE) begin
            cur_d = alloc_head_q;
            if (free_address_i == '0) begin
              res_status_d = ST_IGNORED;
              state_d      = S_FIN;
            end else begin
              state_d = S_F_RD;
            end
          end else begin
            cur_d = free_head_q;
            if (alloc_size_i == '0) begin
              res_status_d = ST_IGNORED;
              state_d      = S_FIN;
            end else if (free_head_q[IW]) begin
              res_status_d = ST_NO_FIT;
              state_d      = S_FIN;
            end else begin
              state_d = S_A_RD;
            end
          end
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IW-1:0];
        tmp_rec   = '0;
        if (cnt_q == '0) begin
          tmp_rec.kind   = KIND_FREE;
          tmp_rec.start  = pool_base_q;
          tmp_rec.length = pool_bytes_q;
        end
        ram_wdata = {NONE, tmp_rec};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[IW-1:0] == IDX_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_A_RD: begin
        ram_re  = 1'b1;
        state_d = S_A_CUR;
      end
      S_A_CUR: begin
        cur_rec_d  = rd_rec;
        cur_link_d = rd_link;
        if (!rd_link[IW]) begin
          ram_re    = 1'b1;
          ram_raddr = rd_link[IW-1:0];
          state_d   = S_A_NXT;
        end else begin
          state_d = S_A_FIT;
        end
      end
      S_A_NXT: begin
        if (end_sum == {1'b0, rd_rec.start}) begin
          cur_rec_d.length = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
          cur_link_d       = rd_link;
          tmp_rec          = rd_rec;
          tmp_rec.kind     = KIND_UNUSED;
          ram_we           = 1'b1;
          ram_waddr        = cur_link_q[IW-1:0];
          ram_wdata        = {NONE, tmp_rec};
          state_d          = S_A_MRG;
        end else begin
          state_d = S_A_FIT;
        end
      end
      S_A_MRG: begin
        ram_we  = 1'b1;
        state_d = S_A_FIT;
      end
      S_A_FIT: begin
        cnt_d  = '0;
        pend_d = 1'b0;
        if (cur_rec_q.length < size_q) begin
          prev_d     = cur_q;
          prev_rec_d = cur_rec_q;
          cur_d      = cur_link_q;
          if (cur_link_q[IW]) begin
            res_status_d = ST_NO_FIT;
            state_d      = S_FIN;
          end else begin
            state_d = S_A_RD;
          end
        end else if (cur_rec_q.length == size_q) begin
          exact_d = 1'b1;
          if (prev_q[IW]) begin
            free_head_d = cur_link_q;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_q[IW-1:0];
            ram_wdata = {cur_link_q, prev_rec_q};
          end
          state_d = S_A_REL;
        end else begin
          exact_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_A_REL: begin
        tmp_rec.kind = KIND_UNUSED;
        ram_we       = 1'b1;
        ram_wdata    = {NONE, tmp_rec};
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        if (pend_q && rd_rec.kind == KIND_UNUSED) begin
          if (!exact_q) begin
            tmp_rec.start  = cur_rec_q.start + size_q;
            tmp_rec.length = cur_rec_q.length - size_q;
            ram_we         = 1'b1;
            ram_wdata      = {cur_link_q, tmp_rec};
          end
          d_d            = chk_q;
          d_rec_d.kind   = KIND_ALLOC;
          d_rec_d.start  = cur_rec_q.start;
          d_rec_d.length = size_q;
          ins_alloc_d    = 1'b1;
          cur_d          = alloc_head_q;
          prev_d         = NONE;
          state_d        = S_I_RD;
        end else if (pend_q && chk_q == IDX_LAST) begin
          res_status_d = ST_NO_DESC;
          state_d      = S_FIN;
        end else if (cnt_q != CNT_END) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[IW-1:0];
          chk_d     = cnt_q[IW-1:0];
          pend_d    = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      S_F_RD: begin
        if (cur_q[IW]) begin
          res_status_d = ST_IGNORED;
          state_d      = S_FIN;
        end else begin
          ram_re  = 1'b1;
          state_d = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (rd_rec.start == addr_q) begin
          if (prev_q[IW]) begin
            alloc_head_d = rd_link;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_q[IW-1:0];
            ram_wdata = {rd_link, prev_rec_q};
          end
          d_d          = cur_q[IW-1:0];
          d_rec_d      = rd_rec;
          d_rec_d.kind = KIND_FREE;
          ins_alloc_d  = 1'b0;
          cur_d        = free_head_q;
          prev_d       = NONE;
          state_d      = S_I_RD;
        end else begin
          prev_d     = cur_q;
          prev_rec_d = rd_rec;
          cur_d      = rd_link;
          state_d    = S_F_RD;
        end
      end
      S_I_RD: begin
        if (cur_q[IW]) begin
          state_d = S_I_WR1;
        end else begin
          ram_re  = 1'b1;
          state_d = S_I_CHK;
        end
      end
      S_I_CHK: begin
        if (rd_rec.start < d_rec_q.start) begin
          prev_d     = cur_q;
          prev_rec_d = rd_rec;
          cur_d      = rd_link;
          state_d    = S_I_RD;
        end else begin
          state_d = S_I_WR1;
        end
      end
      S_I_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = d_q;
        ram_wdata = {cur_q, d_rec_q};
        state_d   = S_I_WR2;
      end
      S_I_WR2: begin
        if (prev_q[IW]) begin
          if (ins_alloc_q) begin
            alloc_head_d = {1'b0, d_q};
          end else begin
            free_head_d = {1'b0, d_q};
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = prev_q[IW-1:0];
          ram_wdata = {{1'b0, d_q}, prev_rec_q};
        end
        res_status_d = ST_DONE;
        res_addr_d   = ins_alloc_q ? d_rec_q.start : '0;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_hit) begin
      if (cfg_index_i == REG_POOL_BASE) begin
        pool_base_d = cfg_data_i;
      end else begin
        pool_bytes_d = cfg_data_i;
      end
      cnt_d        = '0;
      free_head_d  = '0;
      alloc_head_d = NONE;
      state_d      = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      free_head_q  <= '0;
      alloc_head_q <= NONE;
      pool_base_q  <= POOL_BASE_RESET;
      pool_bytes_q <= POOL_BYTES_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      free_head_q  <= free_head_d;
      alloc_head_q <= alloc_head_d;
      pool_base_q  <= pool_base_d;
      pool_bytes_q <= pool_bytes_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    cur_link_q   <= cur_link_d;
    cur_rec_q    <= cur_rec_d;
    prev_rec_q   <= prev_rec_d;
    d_rec_q      <= d_rec_d;
    exact_q      <= exact_d;
    ins_alloc_q  <= ins_alloc_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    d_q          <= d_d;
    chk_q        <= chk_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  ffra_ram #(
    .WIDTH(W),
    .DEPTH(DESCRIPTORS)
  ) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> state_q == S_CLR)
    else $error("register write did not start the clearing pass");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("descriptor read and write hit the same entry");

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !cfg_hit) |=> !in_ready_o)
    else $error("second transaction accepted while one is in progress");

  a_free_head_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q[IW] || free_head_q[IW-1:0] <= IDX_LAST)
    else $error("free list head out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> state_q == S_FIN)
    else $error("result overwritten before the waiting one was taken");

endmodule
